// ----- hw/rtl/label_palette_table_assert.svh -----
// ---------------------------------------------------------------------------
// label_palette_table assertion macros
// Shared concurrent check forms, clocked on clk and disabled during rst_n low.
// ---------------------------------------------------------------------------
`ifndef LABEL_PALETTE_TABLE_ASSERT_SVH
`define LABEL_PALETTE_TABLE_ASSERT_SVH

// same-cycle implication
`define LPT_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define LPT_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- hw/rtl/lpt_pkg.sv -----
// ---------------------------------------------------------------------------
// lpt_pkg
// Types and fixed constants of the label palette table.
// ---------------------------------------------------------------------------
`default_nettype none

package lpt_pkg;

  typedef enum logic [1:0] {
    ACT_INSERT   = 2'd0,
    ACT_GENERATE = 2'd1,
    ACT_CLEAR    = 2'd2,
    ACT_LOOKUP   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_SECT,
    ST_SCALE,
    ST_RECIP,
    ST_MIX,
    ST_DONE
  } state_t;

  // hue sectors of 60 degrees
  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_t;

  // hue = 359 * 256 * i / g, 8 fraction bits
  localparam int unsigned HUE_SCALE    = 91904;
  localparam int unsigned HQ_W         = 17;
  // 60 degrees in hue units
  localparam int unsigned SECTOR_Q     = 15360;
  localparam int unsigned X_W          = 14;
  // 15360 = 1024 * 15: shift, then multiply by ceil(2^24 / 15)
  localparam int unsigned SECTOR_SHIFT = 10;
  localparam int unsigned RECIP_15     = 1118482;
  localparam int unsigned RECIP_W      = 21;
  localparam int unsigned RECIP_SHIFT  = 24;

endpackage

`default_nettype wire

// ----- hw/rtl/lpt_ram.sv -----
// ---------------------------------------------------------------------------
// lpt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module lpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- hw/rtl/lpt_div.sv -----
// ---------------------------------------------------------------------------
// lpt_div
// Iterative restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module lpt_div #(
  parameter int DVD_W = 23,
  parameter int DVS_W = 7
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic      [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign rem_sh = {rem_r, quo_r[DVD_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DVD_W);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ----- hw/rtl/label_palette_table.sv -----
// ---------------------------------------------------------------------------
// label_palette_table
// Table of distinct labels, each mapped to an evenly spaced HSV hue (S=V=1).
//
// Channels: in_* (in_action, in_label) and out_* results, valid/ready each.
// One result per transfer. Actions: insert, generate, clear, lookup.
// Insert and lookup scan the label RAM one entry per cycle up to the count of
// labels held, stopping at a match. A lookup that hits a coloured entry adds
// one divider pass and 4 colour stages (sector, scale, reciprocal, mix).
// Generate and clear skip the scan and the colour stages.
// One item is in work at a time; the scan loop over the RAM, and for a
// coloured hit the divider and colour stages, set the rate.
// in_ready is high whenever no item is in work, even while a result waits
// in the output register; a stalled receiver holds the finished item back
// until the output register frees.
// Reset empties the table and the coloured count at once; the label RAM
// holds no reset and its data is used only below the fill count.
// ---------------------------------------------------------------------------
`default_nettype none
`include "label_palette_table_assert.svh"

module label_palette_table
  import lpt_pkg::*;
#(
  parameter int DEPTH         = 64,
  parameter int LABEL_WIDTH   = 32,
  parameter int CHANNEL_WIDTH = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [1:0]                       in_action,
  input  wire logic [31:0]                      in_label,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_hit,
  output logic                                  out_table_full,
  output logic      [$clog2(DEPTH)-1:0]         out_entry_index,
  output logic      [CHANNEL_WIDTH-1:0]         out_red,
  output logic      [CHANNEL_WIDTH-1:0]         out_green,
  output logic      [CHANNEL_WIDTH-1:0]         out_blue,
  output logic      [$clog2(DEPTH+1)-1:0]       out_entry_count
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int NUM_W = $clog2(HUE_SCALE * DEPTH);
  localparam int PX_W  = CHANNEL_WIDTH + X_W;
  localparam int V_W   = PX_W - SECTOR_SHIFT;
  localparam int PP_W  = V_W + RECIP_W;
  localparam logic [CHANNEL_WIDTH-1:0] CH_MAX = '1;

  state_t                   state_r, state_nxt;
  action_t                  act_r, act_nxt;
  logic [LABEL_WIDTH-1:0]   key_r, key_nxt;
  logic [CNT_W-1:0]         scan_addr_r, scan_addr_nxt;
  logic                     rd_pend_r, rd_pend_nxt;
  logic [IDX_W-1:0]         rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]         label_count_r, label_count_nxt;
  logic [CNT_W-1:0]         gen_count_r, gen_count_nxt;

  logic                     res_hit_r, res_hit_nxt;
  logic                     res_full_r, res_full_nxt;
  logic [IDX_W-1:0]         res_idx_r, res_idx_nxt;
  logic [CHANNEL_WIDTH-1:0] res_red_r, res_red_nxt;
  logic [CHANNEL_WIDTH-1:0] res_green_r, res_green_nxt;
  logic [CHANNEL_WIDTH-1:0] res_blue_r, res_blue_nxt;

  logic [HQ_W-1:0]          hq_r, hq_nxt;
  sector_t                  sect_r, sect_nxt;
  logic [X_W-1:0]           x_r, x_nxt;
  logic [PX_W-1:0]          px_r, px_nxt;
  logic [PP_W-1:0]          pp_r, pp_nxt;

  logic                     out_valid_r;
  logic                     out_hit_r;
  logic                     out_full_r;
  logic [IDX_W-1:0]         out_idx_r;
  logic [CHANNEL_WIDTH-1:0] out_red_r;
  logic [CHANNEL_WIDTH-1:0] out_green_r;
  logic [CHANNEL_WIDTH-1:0] out_blue_r;
  logic [CNT_W-1:0]         out_count_r;

  logic                     in_fire;
  logic                     out_load;
  logic                     match;
  logic                     scan_end;
  logic                     go_colour;
  logic                     issue;
  logic                     mem_we;
  logic [LABEL_WIDTH-1:0]   rd_data;
  logic                     div_start;
  logic                     div_done;
  logic [NUM_W-1:0]         div_quo;
  logic [NUM_W-1:0]         dividend;
  logic [HQ_W-1:0]          t_c;
  logic [HQ_W-1:0]          d_c;
  logic [CHANNEL_WIDTH-1:0] part_c;

  // ------------------------------------------------------------------
  // Label RAM and hue divider
  // ------------------------------------------------------------------
  lpt_ram #(
    .WIDTH (LABEL_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (label_count_r[IDX_W-1:0]),
    .wdata (key_r),
    .raddr (scan_addr_r[IDX_W-1:0]),
    .rdata (rd_data)
  );

  assign dividend = NUM_W'(HUE_SCALE) * NUM_W'(rd_idx_r);

  lpt_div #(
    .DVD_W (NUM_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (gen_count_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // ------------------------------------------------------------------
  // Control terms
  // ------------------------------------------------------------------
  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign match     = rd_pend_r && (rd_data == key_r);
  assign scan_end  = match || (!rd_pend_r && (scan_addr_r >= label_count_r));
  assign go_colour = match && (act_r == ACT_LOOKUP) && (CNT_W'(rd_idx_r) < gen_count_r);
  assign issue     = (state_r == ST_SCAN) && !match && (scan_addr_r < label_count_r);
  assign div_start = (state_r == ST_SCAN) && go_colour;
  assign mem_we    = (state_r == ST_SCAN) && scan_end && !match && (act_r == ACT_INSERT)
                     && (label_count_r < CNT_W'(DEPTH));

  // ------------------------------------------------------------------
  // Next state
  // ------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if ((action_t'(in_action) == ACT_INSERT) || (action_t'(in_action) == ACT_LOOKUP)) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_nxt = go_colour ? ST_DIV : ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_SECT;
        end
      end
      ST_SECT:  state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_RECIP;
      ST_RECIP: state_nxt = ST_MIX;
      ST_MIX:   state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ------------------------------------------------------------------
  // Colour sector terms
  // ------------------------------------------------------------------
  always_comb begin
    if (hq_r >= HQ_W'(4 * SECTOR_Q)) begin
      t_c = hq_r - HQ_W'(4 * SECTOR_Q);
    end else if (hq_r >= HQ_W'(2 * SECTOR_Q)) begin
      t_c = hq_r - HQ_W'(2 * SECTOR_Q);
    end else begin
      t_c = hq_r;
    end
    d_c    = (t_c >= HQ_W'(SECTOR_Q)) ? (t_c - HQ_W'(SECTOR_Q)) : (HQ_W'(SECTOR_Q) - t_c);
    part_c = pp_r[RECIP_SHIFT +: CHANNEL_WIDTH];
  end

  // ------------------------------------------------------------------
  // Datapath next values
  // ------------------------------------------------------------------
  always_comb begin
    act_nxt         = act_r;
    key_nxt         = key_r;
    scan_addr_nxt   = scan_addr_r;
    rd_pend_nxt     = 1'b0;
    rd_idx_nxt      = rd_idx_r;
    label_count_nxt = label_count_r;
    gen_count_nxt   = gen_count_r;
    res_hit_nxt     = res_hit_r;
    res_full_nxt    = res_full_r;
    res_idx_nxt     = res_idx_r;
    res_red_nxt     = res_red_r;
    res_green_nxt   = res_green_r;
    res_blue_nxt    = res_blue_r;
    hq_nxt          = hq_r;
    sect_nxt        = sect_r;
    x_nxt           = x_r;
    px_nxt          = px_r;
    pp_nxt          = pp_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          act_nxt       = action_t'(in_action);
          key_nxt       = LABEL_WIDTH'(in_label);
          scan_addr_nxt = '0;
          res_hit_nxt   = 1'b0;
          res_full_nxt  = 1'b0;
          res_idx_nxt   = '0;
          res_red_nxt   = '0;
          res_green_nxt = '0;
          res_blue_nxt  = '0;
          if (action_t'(in_action) == ACT_GENERATE) begin
            gen_count_nxt = label_count_r;
          end else if (action_t'(in_action) == ACT_CLEAR) begin
            label_count_nxt = '0;
            gen_count_nxt   = '0;
          end
        end
      end
      ST_SCAN: begin
        rd_pend_nxt = issue;
        if (issue) begin
          rd_idx_nxt    = scan_addr_r[IDX_W-1:0];
          scan_addr_nxt = scan_addr_r + CNT_W'(1);
        end
        if (match) begin
          res_hit_nxt = 1'b1;
          res_idx_nxt = rd_idx_r;
        end else if (scan_end && (act_r == ACT_INSERT)) begin
          if (mem_we) begin
            res_idx_nxt     = label_count_r[IDX_W-1:0];
            label_count_nxt = label_count_r + CNT_W'(1);
          end else begin
            res_full_nxt = 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          hq_nxt = div_quo[HQ_W-1:0];
        end
      end
      ST_SECT: begin
        if (hq_r < HQ_W'(SECTOR_Q)) begin
          sect_nxt = SEC_RY;
        end else if (hq_r < HQ_W'(2 * SECTOR_Q)) begin
          sect_nxt = SEC_YG;
        end else if (hq_r < HQ_W'(3 * SECTOR_Q)) begin
          sect_nxt = SEC_GC;
        end else if (hq_r < HQ_W'(4 * SECTOR_Q)) begin
          sect_nxt = SEC_CB;
        end else if (hq_r < HQ_W'(5 * SECTOR_Q)) begin
          sect_nxt = SEC_BM;
        end else begin
          sect_nxt = SEC_MR;
        end
        x_nxt = X_W'(HQ_W'(SECTOR_Q) - d_c);
      end
      ST_SCALE: begin
        px_nxt = PX_W'(CH_MAX) * PX_W'(x_r);
      end
      ST_RECIP: begin
        pp_nxt = PP_W'(px_r[PX_W-1:SECTOR_SHIFT]) * PP_W'(RECIP_15);
      end
      ST_MIX: begin
        case (sect_r)
          SEC_RY: begin
            res_red_nxt   = CH_MAX;
            res_green_nxt = part_c;
          end
          SEC_YG: begin
            res_red_nxt   = part_c;
            res_green_nxt = CH_MAX;
          end
          SEC_GC: begin
            res_green_nxt = CH_MAX;
            res_blue_nxt  = part_c;
          end
          SEC_CB: begin
            res_green_nxt = part_c;
            res_blue_nxt  = CH_MAX;
          end
          SEC_BM: begin
            res_red_nxt   = part_c;
            res_blue_nxt  = CH_MAX;
          end
          default: begin
            res_red_nxt   = CH_MAX;
            res_blue_nxt  = part_c;
          end
        endcase
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // ------------------------------------------------------------------
  // Registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      rd_pend_r     <= 1'b0;
      label_count_r <= '0;
      gen_count_r   <= '0;
    end else begin
      state_r       <= state_nxt;
      rd_pend_r     <= rd_pend_nxt;
      label_count_r <= label_count_nxt;
      gen_count_r   <= gen_count_nxt;
    end
    act_r       <= act_nxt;
    key_r       <= key_nxt;
    scan_addr_r <= scan_addr_nxt;
    rd_idx_r    <= rd_idx_nxt;
    res_hit_r   <= res_hit_nxt;
    res_full_r  <= res_full_nxt;
    res_idx_r   <= res_idx_nxt;
    res_red_r   <= res_red_nxt;
    res_green_r <= res_green_nxt;
    res_blue_r  <= res_blue_nxt;
    hq_r        <= hq_nxt;
    sect_r      <= sect_nxt;
    x_r         <= x_nxt;
    px_r        <= px_nxt;
    pp_r        <= pp_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_hit_r   <= res_hit_r;
      out_full_r  <= res_full_r;
      out_idx_r   <= res_idx_r;
      out_red_r   <= res_red_r;
      out_green_r <= res_green_r;
      out_blue_r  <= res_blue_r;
      out_count_r <= label_count_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_table_full  = out_full_r;
  assign out_entry_index = out_idx_r;
  assign out_red         = out_red_r;
  assign out_green       = out_green_r;
  assign out_blue        = out_blue_r;
  assign out_entry_count = out_count_r;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  `LPT_ASSERT_IMP(a_count_bound, 1'b1, label_count_r <= CNT_W'(DEPTH))
  `LPT_ASSERT_IMP(a_gen_bound, 1'b1, gen_count_r <= label_count_r)
  `LPT_ASSERT_IMP(a_write_room, mem_we, label_count_r < CNT_W'(DEPTH))
  `LPT_ASSERT_NXT(a_div_enter, div_start, state_r == ST_DIV)
  `LPT_ASSERT_IMP(a_div_owner, div_done, state_r == ST_DIV)

endmodule

`default_nettype wire
